[rtl/lmip_pkg.sv]
// Package for the LWE batch modular inner product block.
// Holds the shared types, the register index codes and the modular add helper.
package lmip_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned KIDX_W = 10;
    localparam int unsigned DIM_W  = 11;
    localparam int unsigned CTN_W  = 16;

    localparam logic [WORD_W-1:0] MODULUS_RESET   = 64'd1024;
    localparam logic [DIM_W-1:0]  DIMENSION_RESET = 11'd512;

    typedef enum logic {
        CFG_MODULUS   = 1'b0,
        CFG_DIMENSION = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RKEY,
        BK_MUL,
        BK_RACC,
        BK_FIN
    } t_back_state;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] key;
        logic              last;
    } t_work;

    // (x + y) mod q for x, y < q
    function automatic logic [WORD_W-1:0] add_mod(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] q
    );
        logic [WORD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

[rtl/lmip_in_if.sv]
// Input channel: valid/ready handshake with mode, key index and value.
// Depends on lmip_pkg.
interface lmip_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [lmip_pkg::KIDX_W-1:0]  key_index;
    logic [lmip_pkg::WORD_W-1:0]  value;

    modport source (output valid, output mode, output key_index, output value, input ready);
    modport sink   (input valid, input mode, input key_index, input value, output ready);
endinterface

[rtl/lmip_out_if.sv]
// Result channel: valid/ready handshake with ciphertext number and partial sum.
// Depends on lmip_pkg.
interface lmip_out_if;
    logic                        valid;
    logic                        ready;
    logic [lmip_pkg::CTN_W-1:0]  ct_number;
    logic [lmip_pkg::WORD_W-1:0] partial;

    modport source (output valid, output ct_number, output partial, input ready);
    modport sink   (input valid, input ct_number, input partial, output ready);
endinterface

[rtl/lmip_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lmip_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/lmip_fifo.sv]
// Two-entry queue of work transactions between front and back.
// Depends on lmip_pkg.
module lmip_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lmip_pkg::t_work       i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output lmip_pkg::t_work       o_data
);
    import lmip_pkg::*;

    t_work       r_slot [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

[rtl/lmip_front.sv]
// Front end: accepts transactions, writes key words, reads the key for each coefficient.
// Depends on lmip_pkg, lmip_in_if and lmip_ram.
module lmip_front #(
    parameter int unsigned MAX_DIMENSION = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lmip_in_if.sink                      i_in,
    input  logic [lmip_pkg::DIM_W-1:0]   i_dimension,
    input  logic                         i_full,
    output logic                         o_push,
    output lmip_pkg::t_work              o_work
);
    import lmip_pkg::*;

    localparam int unsigned AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int unsigned LW = $clog2(MAX_DIMENSION + 1) + 1;

    logic              r_pend;
    logic [WORD_W-1:0] r_val;
    logic              r_last;
    logic [AW-1:0]     r_cnt;
    logic [WORD_W-1:0] key_rd;
    logic [LW-1:0]     len;
    logic              last;
    logic              accept;
    logic              key_we;

    always_comb begin
        priority if (i_dimension == '0) begin
            len = LW'(1);
        end else if (32'(i_dimension) > MAX_DIMENSION) begin
            len = LW'(MAX_DIMENSION);
        end else begin
            len = LW'(i_dimension);
        end
    end

    assign last     = ((LW'(r_cnt) + LW'(1)) >= len);
    assign i_in.ready = !r_pend && !i_full;
    assign accept   = i_in.valid && i_in.ready;
    assign key_we   = accept && !i_in.mode && (32'(i_in.key_index) < MAX_DIMENSION);

    lmip_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIMENSION), .AW(AW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (AW'(i_in.key_index)),
        .i_wdata (i_in.value),
        .i_raddr (r_cnt),
        .o_rdata (key_rd)
    );

    assign o_push       = r_pend;
    assign o_work.value = r_val;
    assign o_work.key   = key_rd;
    assign o_work.last  = r_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val  <= i_in.value;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_pend <= accept && i_in.mode;
            if (accept && i_in.mode) begin
                r_cnt <= last ? '0 : r_cnt + AW'(1);
            end
        end
    end
endmodule

[rtl/lmip_mulmod.sv]
// Serial modular multiplier: a * b mod q, one doubling or one add per cycle.
// Depends on lmip_pkg; b must already be below q.
module lmip_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lmip_pkg::WORD_W-1:0] i_a,
    input  logic [lmip_pkg::WORD_W-1:0] i_b,
    input  logic [lmip_pkg::WORD_W-1:0] i_q,
    output logic                        o_done,
    output logic [lmip_pkg::WORD_W-1:0] o_r
);
    import lmip_pkg::*;

    logic              r_busy;
    logic              r_phase;
    logic [5:0]        r_bit;
    logic [WORD_W-1:0] r_a, r_b, r_r;

    assign o_r = r_r;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_r <= add_mod(r_r, r_r, i_q);
            end else begin
                if (r_a[WORD_W-1]) begin
                    r_r <= add_mod(r_r, r_b, i_q);
                end
                r_a <= {r_a[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_bit   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_bit   <= '1;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == '0) begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end
                end
            end
        end
    end
endmodule

[rtl/lmip_back.sv]
// Back end: reduces operands, multiplies, accumulates mod q and emits the results.
// Depends on lmip_pkg, lmip_out_if and lmip_mulmod.
module lmip_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  lmip_pkg::t_work             i_work,
    output logic                        o_pop,
    input  logic [lmip_pkg::WORD_W-1:0] i_modulus,
    lmip_out_if.source                  o_out
);
    import lmip_pkg::*;

    t_back_state       r_state, n_state;
    logic [WORD_W-1:0] r_val, r_prod, r_acc;
    logic              r_last;
    logic [CTN_W-1:0]  r_ctn;
    logic              r_ovalid;
    logic [CTN_W-1:0]  r_octn;
    logic [WORD_W-1:0] r_opart;
    logic              degen, out_free, emit;
    logic              mm_start, mm_done;
    logic [WORD_W-1:0] mm_a, mm_b, mm_r;

    assign degen    = (i_modulus < 64'd2);
    assign out_free = !r_ovalid || o_out.ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.ct_number = r_octn;
    assign o_out.partial   = r_opart;

    lmip_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_q     (i_modulus),
        .o_done  (mm_done),
        .o_r     (mm_r)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_valid) begin
                n_state = degen ? BK_FIN : BK_RKEY;
            end
            BK_RKEY: if (mm_done) begin
                n_state = BK_MUL;
            end
            BK_MUL: if (mm_done) begin
                n_state = BK_RACC;
            end
            BK_RACC: if (mm_done) begin
                n_state = BK_FIN;
            end
            BK_FIN: if (!r_last || out_free) begin
                n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        mm_start = 1'b0;
        mm_a     = r_acc;
        mm_b     = {{(WORD_W-1){1'b0}}, 1'b1};
        emit     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop    = i_valid;
                mm_start = i_valid && !degen;
                mm_a     = i_work.key;
            end
            BK_RKEY: begin
                mm_start = mm_done;
                mm_a     = r_val;
                mm_b     = mm_r;
            end
            BK_MUL: begin
                mm_start = mm_done;
            end
            BK_RACC: begin
            end
            BK_FIN: begin
                emit = r_last && out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val  <= i_work.value;
            r_last <= i_work.last;
        end
        if (r_state == BK_MUL && mm_done) begin
            r_prod <= mm_r;
        end
        if (emit) begin
            r_octn  <= r_ctn;
            r_opart <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_acc    <= '0;
            r_ctn    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && degen) begin
                r_acc <= '0;
            end else if (r_state == BK_RACC && mm_done) begin
                r_acc <= add_mod(mm_r, r_prod, i_modulus);
            end else if (emit) begin
                r_acc <= '0;
            end
            if (emit) begin
                r_ctn    <= r_ctn + CTN_W'(1);
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

[rtl/lwe_batch_modular_inner_product.sv]
// LWE batch modular inner product: top level with configuration registers.
// Depends on lmip_pkg, lmip_in_if, lmip_out_if, lmip_front, lmip_fifo, lmip_back.
//
// Use: load key words with mode 0 (value written at key_index), then stream
// ciphertext coefficients with mode 1, dimension coefficients per ciphertext.
// After the last coefficient of each ciphertext one result transaction carries
// the running ciphertext number and the inner product with the key modulo q.
// A coefficient passes through the front (key read) and then through the back:
// three serial modular multiplications (key reduction, product, accumulator
// reduction) plus the final add; that serial multiplier sets the rate.
// A two-entry queue lets the front keep taking transactions while the back works.
// The result sits in an output register; a stalled receiver holds it there and
// the back waits only when the next result is due. Synchronous reset clears the
// accumulator, counters and handshakes; key words must be written before use.
// Write configuration only while no transaction is in flight.
module lwe_batch_modular_inner_product #(
    parameter int unsigned MAX_DIMENSION = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lmip_in_if.sink                     i_in,
    lmip_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [lmip_pkg::WORD_W-1:0] i_cfg_data
);
    import lmip_pkg::*;

    logic [WORD_W-1:0] r_modulus;
    logic [DIM_W-1:0]  r_dimension;
    logic              q_full, q_push, q_valid, q_pop;
    t_work             q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RESET;
            r_dimension <= DIMENSION_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODULUS:   r_modulus   <= i_cfg_data;
                CFG_DIMENSION: r_dimension <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lmip_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_dimension (r_dimension),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_work      (q_in)
    );

    lmip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    lmip_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_work    (q_out),
        .o_pop     (q_pop),
        .i_modulus (r_modulus),
        .o_out     (o_out)
    );
endmodule
